FILE: rtl/vnt_pkg.sv
// ----------------------------------------------------------------------------
// vnt_pkg: shared types and constants for the value noise texture fill
// Word layouts, register indexes, hash multipliers and pipeline depth.
// ----------------------------------------------------------------------------
package vnt_pkg;

    // pipeline depth, input register through output register
    localparam int PIPE_DEPTH = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_XY  = HASH_MUL_X + HASH_MUL_Y;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam logic [15:0] FREQ_RESET = 16'd9830;
    localparam logic [15:0] Q16_HALF   = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_RED   = 3'd0,
        CFG_BASE_GREEN = 3'd1,
        CFG_BASE_BLUE  = 3'd2,
        CFG_VARIANCE   = 3'd3,
        CFG_FREQUENCY  = 3'd4,
        CFG_OFFSET_X   = 3'd5,
        CFG_OFFSET_Y   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0] pixel_x;
        logic [5:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

endpackage

FILE: rtl/vnt_blend.sv
// ----------------------------------------------------------------------------
// vnt_blend: registered Q0.16 linear blend
// y = (p*(1-s) + q*s) >> 16, computed as p + ((q-p)*s >> 16).
// ----------------------------------------------------------------------------
module vnt_blend (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_p,
    input  logic [15:0] i_q,
    input  logic [15:0] i_s,
    output logic [15:0] o_y
);

    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] acc;
    logic        [15:0] r_y;

    // p*65536 is whole, so the floor of the sum equals the floor of the model's form
    always_comb begin
        diff = $signed({1'b0, i_q}) - $signed({1'b0, i_p});
        prod = 34'(diff) * 34'($signed({1'b0, i_s}));
        acc  = $signed({2'b00, i_p, 16'h0000}) + prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= acc[31:16];
        end
    end

    assign o_y = r_y;

endmodule

FILE: rtl/value_noise_texture_fill.sv
// ----------------------------------------------------------------------------
// value_noise_texture_fill: smoothstep value noise over a base RGB color
// Pipeline: 7 register stages, stage 0 through stage 6,
// the first loaded at the accept edge.
// Throughput: one word per cycle while the output accepts; ready drops only when every stage is full.
// Reset (synchronous, active low) empties the pipe, frequency 9830, rest 0.
// ----------------------------------------------------------------------------
module value_noise_texture_fill
    import vnt_pkg::*;
#(
    parameter int TILE_EDGE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pix_in               i_in_data,
    // color output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_pix_out              o_out_data
);

    // largest coordinate kept; anything above saturates to it
    localparam logic [7:0] PIX_MAX = 8'(TILE_EDGE - 1);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [7:0]  r_base_red;
    logic [7:0]  r_base_green;
    logic [7:0]  r_base_blue;
    logic [7:0]  r_variance;
    logic [15:0] r_frequency;
    logic [23:0] r_offset_x;
    logic [23:0] r_offset_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_red   <= '0;
            r_base_green <= '0;
            r_base_blue  <= '0;
            r_variance   <= '0;
            r_frequency  <= FREQ_RESET;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_RED:   r_base_red   <= i_cfg_data[7:0];
                CFG_BASE_GREEN: r_base_green <= i_cfg_data[7:0];
                CFG_BASE_BLUE:  r_base_blue  <= i_cfg_data[7:0];
                CFG_VARIANCE:   r_variance   <= i_cfg_data[7:0];
                CFG_FREQUENCY:  r_frequency  <= i_cfg_data[15:0];
                CFG_OFFSET_X:   r_offset_x   <= i_cfg_data[23:0];
                CFG_OFFSET_Y:   r_offset_y   <= i_cfg_data[23:0];
                default: ;  // index past the list: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // A stage loads when it is empty or its contents move on. Bubbles
    // are squeezed out, so a stall at the output backs up stage by stage.
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] adv;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic                  in_fire;
    logic                  out_fire;

    always_comb begin
        adv[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld[0] = adv[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];
    assign in_fire     = i_in_valid && adv[0];
    assign out_fire    = r_vld[PIPE_DEPTH-1] && i_out_ready;

    // ------------------------------------------------------------------
    // Stage 0: saturate coordinates, position = pixel*freq + offset (Q8.16)
    // ------------------------------------------------------------------
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [23:0] n0_px;
    logic [23:0] n0_py;
    logic [23:0] r0_px;
    logic [23:0] r0_py;

    always_comb begin
        cx = ({2'b00, i_in_data.pixel_x} > PIX_MAX) ? PIX_MAX[5:0] : i_in_data.pixel_x;
        cy = ({2'b00, i_in_data.pixel_y} > PIX_MAX) ? PIX_MAX[5:0] : i_in_data.pixel_y;
        // sum wraps modulo 2^24
        n0_px = 24'(cx) * 24'(r_frequency) + r_offset_x;
        n0_py = 24'(cy) * 24'(r_frequency) + r_offset_y;
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_px <= n0_px;
            r0_py <= n0_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: lattice hash seed for the low corner, fraction squares.
    // The other three corners differ from it by a constant, added later.
    // ------------------------------------------------------------------
    logic [31:0] n1_h;
    logic [31:0] r1_h;
    logic [15:0] r1_fx;
    logic [15:0] r1_fy;
    logic [31:0] r1_ffx;
    logic [31:0] r1_ffy;

    assign n1_h = 32'(r0_px[23:16]) * HASH_MUL_X + 32'(r0_py[23:16]) * HASH_MUL_Y;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_h   <= n1_h;
            r1_fx  <= r0_px[15:0];
            r1_fy  <= r0_py[15:0];
            r1_ffx <= 32'(r0_px[15:0]) * 32'(r0_px[15:0]);
            r1_ffy <= 32'(r0_py[15:0]) * 32'(r0_py[15:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-corner xor-shift, smoothstep weights
    // corner order: 0 = (i,j), 1 = (i+1,j), 2 = (i,j+1), 3 = (i+1,j+1)
    // ------------------------------------------------------------------
    logic [31:0] h2 [4];
    logic [31:0] r2_t [4];
    logic [17:0] tx;
    logic [17:0] ty;
    logic [49:0] sx_prod;
    logic [49:0] sy_prod;
    logic [15:0] r2_sx;
    logic [15:0] r2_sy;

    always_comb begin
        h2[0] = r1_h;
        h2[1] = r1_h + HASH_MUL_X;
        h2[2] = r1_h + HASH_MUL_Y;
        h2[3] = r1_h + HASH_MUL_XY;
        // 3 - 2f in Q.16
        tx = 18'(3 * 65536) - {1'b0, r1_fx, 1'b0};
        ty = 18'(3 * 65536) - {1'b0, r1_fy, 1'b0};
        sx_prod = 50'(r1_ffx) * 50'(tx);
        sy_prod = 50'(r1_ffy) * 50'(ty);
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int c = 0; c < 4; c++) begin
                r2_t[c] <= h2[c] ^ (h2[c] >> 13);
            end
            r2_sx <= sx_prod[47:32];
            r2_sy <= sy_prod[47:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: mixing multiply, one constant multiplier per corner
    // ------------------------------------------------------------------
    logic [31:0] r3_m [4];
    logic [15:0] r3_sx;
    logic [15:0] r3_sy;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int c = 0; c < 4; c++) begin
                r3_m[c] <= r2_t[c] * HASH_MUL_MIX;
            end
            r3_sx <= r2_sx;
            r3_sy <= r2_sy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final fold to Q0.16 corner values, blend along X
    // ------------------------------------------------------------------
    logic [15:0] val [4];
    logic [15:0] blend_a;
    logic [15:0] blend_b;
    logic [15:0] r4_sy;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            val[c] = r3_m[c][15:0] ^ r3_m[c][31:16];
        end
    end

    vnt_blend u_blend_row0 (
        .i_clk (i_clk),
        .i_en  (adv[4]),
        .i_p   (val[0]),
        .i_q   (val[1]),
        .i_s   (r3_sx),
        .o_y   (blend_a)
    );

    vnt_blend u_blend_row1 (
        .i_clk (i_clk),
        .i_en  (adv[4]),
        .i_p   (val[2]),
        .i_q   (val[3]),
        .i_s   (r3_sx),
        .o_y   (blend_b)
    );

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_sy <= r3_sy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: blend along Y gives the noise value n in Q0.16
    // ------------------------------------------------------------------
    logic [15:0] noise;

    vnt_blend u_blend_col (
        .i_clk (i_clk),
        .i_en  (adv[5]),
        .i_p   (blend_a),
        .i_q   (blend_b),
        .i_s   (r4_sy),
        .o_y   (noise)
    );

    // ------------------------------------------------------------------
    // Stage 6: centered swing (truncated toward zero), add, clamp.
    // Swing magnitude never exceeds 127, so the sum fits 10 signed bits.
    // ------------------------------------------------------------------
    logic [15:0]        noise_dev;
    logic [23:0]        swing_prod;
    logic [6:0]         swing_mag;
    logic signed [9:0]  swing;
    t_pix_out           n6_out;
    t_pix_out           r6_out;

    function automatic logic [7:0] clamp_chan(input logic [7:0] base,
                                              input logic signed [9:0] sw);
        logic signed [9:0] sum;
        sum = $signed({2'b00, base}) + sw;
        if (sum < 0) begin
            return 8'd0;
        end else if (sum > 10'sd255) begin
            return 8'd255;
        end
        return sum[7:0];
    endfunction

    always_comb begin
        noise_dev  = noise[15] ? {1'b0, noise[14:0]} : (Q16_HALF - noise);
        swing_prod = 24'(noise_dev) * 24'(r_variance);
        swing_mag  = swing_prod[22:16];
        swing      = noise[15] ? $signed({3'b000, swing_mag})
                               : -$signed({3'b000, swing_mag});
        n6_out.red_out   = clamp_chan(r_base_red, swing);
        n6_out.green_out = clamp_chan(r_base_green, swing);
        n6_out.blue_out  = clamp_chan(r_base_blue, swing);
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_out <= n6_out;
        end
    end

    assign o_out_data = r6_out;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // words in flight change only by what enters and what leaves
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_vld) ==
                 $past($countones(r_vld)) + int'($past(in_fire)) - int'($past(out_fire)))
        else $error("pipeline occupancy lost or duplicated a word");

    // input is refused only when every stage holds a word
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // a held first stage keeps its position
    a_hold_stage0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !adv[0]) |=> (r_vld[0] && $stable(r0_px) && $stable(r0_py)))
        else $error("stalled first stage changed");

endmodule
